### rtl/ptd_pkg.sv
package ptd_pkg;

  localparam int TICK_W = 16;
  localparam int SLOT_W = 8;
  localparam int PER_W = 16;
  localparam int MAX_RESULTS = 8;
  localparam int FOUND_W = 4;

  // Input opcodes.
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_CREATE  = 3'd1;
  localparam logic [2:0] OP_SUSPEND = 3'd2;
  localparam logic [2:0] OP_RESUME  = 3'd3;
  localparam logic [2:0] OP_DELETE  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_USED   = 2'd1;
  localparam logic [1:0] ST_NOTASK = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  // Status of the remainder unit, handed back to the dispatcher.
  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

endpackage

### rtl/ptd_rem.sv
module ptd_rem
  import ptd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TICK_W-1:0] dividend,
  input  logic [PER_W-1:0]  divisor,
  output rem_stat_t         stat
);

  // Restoring remainder, one dividend bit per cycle, MSB first.
  localparam int CNT_W = $clog2(TICK_W + 1);

  logic [PER_W-1:0]  rem_r;
  logic [PER_W-1:0]  rem_nxt;
  logic [TICK_W-1:0] dvd_r;
  logic [PER_W-1:0]  dsr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r;
  logic              done_r;
  logic [PER_W:0]    trial;

  always_comb begin
    trial = {rem_r, dvd_r[TICK_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      trial = trial - {1'b0, dsr_r};
    end
    rem_nxt = trial[PER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(TICK_W);
    end else if (run_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[TICK_W-2:0], 1'b0};
    end
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

### rtl/periodic_task_dispatcher.sv
// Channel   Handshake               Word fields
// -------   ---------------------   ---------------------------------------
// in_       in_valid / in_ready     in_opcode, in_slot, in_period, in_has_task
// out_      out_valid / out_ready   out_fire, out_due_slot, out_status, out_last
//
// A create, suspend, resume or delete command is taken and its single
// result word is loaded into the output register on the same edge.
// A tick walks the slot table: an idle or suspended slot is skipped in the
// walk state, while an eligible slot needs a period memory read, a load and
// the steps of the serial remainder unit, one per dividend bit, so the time
// a tick takes is set by the remainder unit.
// Reset (synchronous, active low) empties the table and clears the tick count;
// the period memory needs no clearing because a slot is read only once a
// create has written it. A stalled output holds the walk and the input.
module periodic_task_dispatcher
  import ptd_pkg::*;
#(
  parameter int TASK_SLOTS = 8
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_opcode,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [PER_W-1:0]  in_period,
  input  logic              in_has_task,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_fire,
  output logic [SLOT_W-1:0] out_due_slot,
  output logic [1:0]        out_status,
  output logic              out_last
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam logic [SLOT_W-1:0] SLOTS_LIM = SLOT_W'(TASK_SLOTS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // Control state.
  logic [2:0]            state_r, state_nxt;
  logic [TICK_W-1:0]     count_r, count_nxt;
  logic [TASK_SLOTS-1:0] occ_r, occ_nxt;
  logic [TASK_SLOTS-1:0] sus_r, sus_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [FOUND_W-1:0]    found_r, found_nxt;

  // Payload registers.
  logic [IDX_W-1:0]      pend_r, pend_nxt;
  logic                  fire_r, fire_nxt;
  logic [SLOT_W-1:0]     due_r, due_nxt;
  logic [1:0]            status_r, status_nxt;
  logic                  last_r, last_nxt;

  // The period table lives in a one-port-write, registered-read memory.
  // Writes happen only in the idle state and reads only during a tick walk,
  // so the two never touch the same entry in the same cycle.
  logic [PER_W-1:0]      period_mem [TASK_SLOTS];
  logic [PER_W-1:0]      rd_data_r;
  logic                  mem_we;
  logic                  rd_en;
  logic                  rem_start;
  rem_stat_t             rem_stat;

  logic                  out_free;
  logic                  in_take;
  logic                  in_range;
  logic [IDX_W-1:0]      in_idx;
  logic [IDX_W-1:0]      walk_idx;
  logic [1:0]            cmd_status;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_take  = in_valid && in_ready;
  assign in_range = (in_slot < SLOTS_LIM);
  assign in_idx   = in_slot[IDX_W-1:0];
  assign walk_idx = idx_r[IDX_W-1:0];

  ptd_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (count_r),
    .divisor  (rd_data_r),
    .stat     (rem_stat)
  );

  // Command checks; the order of the tests follows the status priority.
  always_comb begin
    cmd_status = ST_OK;
    unique case (in_opcode)
      OP_CREATE: begin
        priority if (!in_has_task) begin
          cmd_status = ST_NOTASK;
        end else if (!in_range) begin
          cmd_status = ST_RANGE;
        end else if (occ_r[in_idx]) begin
          cmd_status = ST_USED;
        end
      end
      OP_SUSPEND, OP_RESUME, OP_DELETE: begin
        if (!in_range) begin
          cmd_status = ST_RANGE;
        end
      end
      default: begin
        cmd_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    occ_nxt       = occ_r;
    sus_nxt       = sus_r;
    out_valid_nxt = out_valid_r;
    pend_v_nxt    = pend_v_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    pend_nxt      = pend_r;
    fire_nxt      = fire_r;
    due_nxt       = due_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    rem_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_opcode == OP_TICK) begin
            count_nxt  = count_r + 1'b1;
            idx_nxt    = '0;
            found_nxt  = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = S_WALK;
          end else begin
            out_valid_nxt = 1'b1;
            fire_nxt      = 1'b0;
            due_nxt       = '0;
            status_nxt    = cmd_status;
            last_nxt      = 1'b1;
            if (in_range) begin
              unique case (in_opcode)
                OP_CREATE: begin
                  if (cmd_status == ST_OK) begin
                    occ_nxt[in_idx] = 1'b1;
                    mem_we          = 1'b1;
                  end
                end
                OP_SUSPEND: sus_nxt[in_idx] = 1'b1;
                OP_RESUME:  sus_nxt[in_idx] = 1'b0;
                OP_DELETE:  occ_nxt[in_idx] = 1'b0;
                default: begin
                end
              endcase
            end
          end
        end
      end
      S_WALK: begin
        priority if (idx_r == CNT_W'(TASK_SLOTS) || found_r == FOUND_W'(MAX_RESULTS)) begin
          state_nxt = S_FIN;
        end else if (occ_r[walk_idx] && !sus_r[walk_idx]) begin
          rd_en     = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_LOAD: begin
        // A zero period is never due and must not reach the remainder unit.
        if (rd_data_r == '0) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_WALK;
        end else begin
          rem_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_stat.done) begin
          priority if (!rem_stat.zero) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_WALK;
          end else if (!pend_v_r) begin
            // The first due slot is held back until we know if it is the last.
            pend_v_nxt = 1'b1;
            pend_nxt   = walk_idx;
            found_nxt  = found_r + 1'b1;
            idx_nxt    = idx_r + 1'b1;
            state_nxt  = S_WALK;
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            fire_nxt      = 1'b1;
            due_nxt       = SLOT_W'(pend_r);
            status_nxt    = ST_OK;
            last_nxt      = 1'b0;
            pend_nxt      = walk_idx;
            found_nxt     = found_r + 1'b1;
            idx_nxt       = idx_r + 1'b1;
            state_nxt     = S_WALK;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          fire_nxt      = pend_v_r;
          due_nxt       = pend_v_r ? SLOT_W'(pend_r) : '0;
          status_nxt    = ST_OK;
          last_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      occ_r       <= '0;
      sus_r       <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      idx_r       <= '0;
      found_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      occ_r       <= occ_nxt;
      sus_r       <= sus_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r   <= pend_nxt;
    fire_r   <= fire_nxt;
    due_r    <= due_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      period_mem[in_idx] <= in_period;
    end
    if (rd_en) begin
      rd_data_r <= period_mem[walk_idx];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_fire     = fire_r;
  assign out_due_slot = due_r;
  assign out_status   = status_r;
  assign out_last     = last_r;

endmodule

### dv/ptd_checker.sv
module ptd_checker
  import ptd_pkg::*;
#(
  parameter int TASK_SLOTS = 8
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        in_opcode,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [PER_W-1:0]  in_period,
  input  logic              in_has_task,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_fire,
  input  logic [SLOT_W-1:0] out_due_slot,
  input  logic [1:0]        out_status,
  input  logic              out_last,
  output int unsigned       fail_count,
  output int unsigned       words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              fire;
    logic [SLOT_W-1:0] due_slot;
    logic [1:0]        status;
    logic              last;
  } result_word_t;

  // Shadow copy of the task table.
  logic [TICK_W-1:0] tick_count;
  logic [PER_W-1:0]  period_tbl [TASK_SLOTS];
  logic              occupied   [TASK_SLOTS];
  logic              suspended  [TASK_SLOTS];

  result_word_t due_words [$];
  result_word_t oldest;
  int unsigned  mismatches = 0;
  int unsigned  words_seen = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] dispatcher mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic queue_word(input logic fire, input logic [SLOT_W-1:0] slot,
                            input logic [1:0] status, input logic last);
    result_word_t w;
    w.fire     = fire;
    w.due_slot = slot;
    w.status   = status;
    w.last     = last;
    due_words.push_back(w);
  endtask

  // Applies one command word to the shadow table and queues the words it
  // should produce.
  task automatic predict_dispatch(input logic [2:0] op, input logic [SLOT_W-1:0] slot,
                                  input logic [PER_W-1:0] period, input logic has_task);
    logic [SLOT_W-1:0] due_list [MAX_RESULTS];
    int                found;
    logic              in_range;
    logic [1:0]        status;
    found    = 0;
    in_range = (slot < TASK_SLOTS);
    status   = ST_OK;
    if (op == OP_TICK) begin
      tick_count = tick_count + 1'b1;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if (found < MAX_RESULTS && occupied[i] && !suspended[i] && period_tbl[i] != '0 &&
            (tick_count % period_tbl[i]) == '0) begin
          due_list[found] = SLOT_W'(i);
          found++;
        end
      end
      if (found == 0) begin
        queue_word(1'b0, '0, ST_OK, 1'b1);
      end else begin
        for (int k = 0; k < found; k++) begin
          queue_word(1'b1, due_list[k], ST_OK, k == found - 1);
        end
      end
    end else begin
      case (op)
        OP_CREATE: begin
          if (!has_task) begin
            status = ST_NOTASK;
          end else if (!in_range) begin
            status = ST_RANGE;
          end else if (occupied[slot]) begin
            status = ST_USED;
          end else begin
            period_tbl[slot] = period;
            occupied[slot]   = 1'b1;
          end
        end
        OP_SUSPEND: begin
          if (in_range) suspended[slot] = 1'b1; else status = ST_RANGE;
        end
        OP_RESUME: begin
          if (in_range) suspended[slot] = 1'b0; else status = ST_RANGE;
        end
        OP_DELETE: begin
          if (in_range) occupied[slot] = 1'b0; else status = ST_RANGE;
        end
        default: ;
      endcase
      queue_word(1'b0, '0, status, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tick_count = '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        period_tbl[i] = '0;
        occupied[i]   = 1'b0;
        suspended[i]  = 1'b0;
      end
      due_words.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_dispatch(in_opcode, in_slot, in_period, in_has_task);
      end
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
        end else begin
          oldest = due_words.pop_front();
          if (out_fire !== oldest.fire)
            report_mismatch($sformatf("word %0d fire %b, want %b",
                                      words_seen, out_fire, oldest.fire));
          if (out_due_slot !== oldest.due_slot)
            report_mismatch($sformatf("word %0d due_slot %0d, want %0d",
                                      words_seen, out_due_slot, oldest.due_slot));
          if (out_status !== oldest.status)
            report_mismatch($sformatf("word %0d status %0d, want %0d",
                                      words_seen, out_status, oldest.status));
          if (out_last !== oldest.last)
            report_mismatch($sformatf("word %0d last %b, want %b",
                                      words_seen, out_last, oldest.last));
        end
        words_seen++;
      end
    end
    words_pending <= due_words.size();
    fail_count    <= mismatches;
  end

endmodule

### dv/periodic_task_dispatcher_tb.sv
module periodic_task_dispatcher_tb
  import ptd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TASK_SLOTS   = 8;
  localparam int RANDOM_WORDS = 280;
  // One full slot walk plus margin.
  localparam int WALK_CYCLES  = 19 * TASK_SLOTS + 2;
  // About 310 words, each at most a full walk plus eight stalled result
  // words; the limit is several times the slowest expected run.
  localparam int CYCLE_LIMIT  = 500_000;

  // Every block input holds a known value from time zero.
  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [2:0]        in_opcode   = OP_TICK;
  logic [SLOT_W-1:0] in_slot     = '0;
  logic [PER_W-1:0]  in_period   = '0;
  logic              in_has_task = 1'b0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic              out_fire;
  logic [SLOT_W-1:0] out_due_slot;
  logic [1:0]        out_status;
  logic              out_last;

  int unsigned       fail_count;
  int unsigned       words_pending;
  int unsigned       cycles      = 0;
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_idle_pct = 0;

  periodic_task_dispatcher #(
    .TASK_SLOTS (TASK_SLOTS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_slot      (in_slot),
    .in_period    (in_period),
    .in_has_task  (in_has_task),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_fire     (out_fire),
    .out_due_slot (out_due_slot),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  ptd_checker #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_slot       (in_slot),
    .in_period     (in_period),
    .in_has_task   (in_has_task),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_fire      (out_fire),
    .out_due_slot  (out_due_slot),
    .out_status    (out_status),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result word ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver drops ready on a random share of cycles. The share is
  // changed with a nonblocking write so this block never races the stimulus.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Offers one command word. The sender first idles for a random number of
  // cycles, then raises valid and holds the word until the block takes it.
  // When there is no gap, valid simply stays high across back-to-back words.
  task automatic send_word(input logic [2:0] op, input logic [SLOT_W-1:0] slot,
                           input logic [PER_W-1:0] period, input logic has_task);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_slot     <= slot;
    in_period   <= period;
    in_has_task <= has_task;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random command with a bias toward useful traffic: mostly ticks and
  // in-range slots with short periods, so tasks get created and then fire.
  // A minority of words use full-width slot and period values, null tasks
  // and unknown opcodes to reach every bit and every error path.
  task automatic send_random_word();
    int                pick;
    logic [2:0]        op;
    logic [SLOT_W-1:0] slot;
    logic [PER_W-1:0]  period;
    logic              has_task;
    pick = $urandom_range(99);
    if (pick < 45)      op = OP_TICK;
    else if (pick < 65) op = OP_CREATE;
    else if (pick < 73) op = OP_SUSPEND;
    else if (pick < 81) op = OP_RESUME;
    else if (pick < 93) op = OP_DELETE;
    else                op = 3'($urandom_range(7, OP_DELETE + 1));
    slot = ($urandom_range(9) != 0) ? SLOT_W'($urandom_range(TASK_SLOTS - 1))
                                    : SLOT_W'($urandom);
    pick = $urandom_range(9);
    if (pick < 7)      period = PER_W'($urandom_range(12, 1));
    else if (pick < 8) period = '0;
    else               period = PER_W'($urandom);
    has_task = (op == OP_CREATE) ? ($urandom_range(9) != 0) : 1'($urandom);
    send_word(op, slot, period, has_task);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: the sender idles now and then, the receiver mostly stalls.
    tx_idle_pct = 19;
    rx_idle_pct <= 77;

    // Directed part. An idle tick on an empty table gives a single word
    // with fire clear.
    send_word(OP_TICK, '0, '0, 1'b0);
    // Create checks: a null task is reported before anything else, even for
    // an out-of-range slot; then range; then a slot already in use.
    send_word(OP_CREATE, 8'd0, 16'd1, 1'b0);
    send_word(OP_CREATE, 8'd255, 16'd9, 1'b0);
    send_word(OP_CREATE, 8'd8, 16'd5, 1'b1);
    send_word(OP_CREATE, 8'd0, 16'd1, 1'b1);
    send_word(OP_CREATE, 8'd0, 16'd3, 1'b1);
    // Largest period, and a zero period that must never fire.
    send_word(OP_CREATE, 8'd7, 16'hFFFF, 1'b1);
    send_word(OP_CREATE, 8'd3, 16'd0, 1'b1);
    // Suspending an empty slot sticks through the later create.
    send_word(OP_SUSPEND, 8'd5, '0, 1'b0);
    send_word(OP_CREATE, 8'd5, 16'd2, 1'b1);
    send_word(OP_TICK, '0, '0, 1'b0);
    // Out-of-range suspend, resume and delete change nothing.
    send_word(OP_SUSPEND, 8'd255, '0, 1'b1);
    send_word(OP_RESUME, 8'd8, '0, 1'b0);
    send_word(OP_DELETE, 8'd200, '0, 1'b1);
    send_word(OP_RESUME, 8'd5, '0, 1'b0);
    send_word(OP_TICK, '0, '0, 1'b0);
    send_word(OP_TICK, '0, '0, 1'b0);
    // Several slots due on one tick, reported in ascending order.
    send_word(OP_CREATE, 8'd1, 16'd1, 1'b1);
    send_word(OP_CREATE, 8'd2, 16'd1, 1'b1);
    send_word(OP_CREATE, 8'd4, 16'd1, 1'b1);
    send_word(OP_CREATE, 8'd6, 16'd1, 1'b1);
    send_word(OP_TICK, '0, '0, 1'b0);
    // Unknown opcodes are answered but change nothing.
    for (int op = OP_DELETE + 1; op < 8; op++) begin
      send_word(3'(op), 8'd1, 16'd4, 1'b1);
    end
    send_word(OP_DELETE, 8'd3, '0, 1'b0);
    send_word(OP_TICK, '0, '0, 1'b0);

    for (int k = 0; k < RANDOM_WORDS / 3; k++) send_random_word();

    // Phase two: the roles swap.
    tx_idle_pct = 77;
    rx_idle_pct <= 19;
    for (int k = 0; k < RANDOM_WORDS / 3; k++) send_random_word();

    // Phase three: full throughput on both sides.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    for (int k = 0; k < RANDOM_WORDS - 2 * (RANDOM_WORDS / 3); k++) send_random_word();
    in_valid <= 1'b0;

    // The pending count is registered in the checker, so step once before
    // polling it, then allow a full walk for any stray word to show up.
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (WALK_CYCLES + 20) @(posedge clk);

    if (fail_count == 0 && words_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
